FILE: hw/rtl/ordm_pkg.sv
// Ordered delimiter matcher: shared types and constants.
// Used by the window cell and the top level; depends on nothing.
package ordm_pkg;

    localparam int NUM_DELIMS    = 6;
    localparam int LEN_W         = 4;
    localparam int BYTE_W        = 8;
    localparam int DELIM_W       = 64;
    localparam int LENGTHS_W     = NUM_DELIMS * LEN_W;
    localparam int CUR_W         = 3;
    localparam int START_W       = 16;
    localparam int ADDR_W        = 6;
    localparam int DATA_W        = 64;
    localparam logic [LEN_W-1:0] BSM_MAX = '1;

    typedef enum logic [2:0] {
        REG_COUNT   = 3'd0,
        REG_LENGTHS = 3'd1,
        REG_BYTES_0 = 3'd2,
        REG_BYTES_1 = 3'd3,
        REG_BYTES_2 = 3'd4,
        REG_BYTES_3 = 3'd5,
        REG_BYTES_4 = 3'd6,
        REG_BYTES_5 = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/ordm_cell.sv
// One window cell: holds one text byte, hands it to the next cell and
// compares its incoming byte with the expected delimiter byte. Uses ordm_pkg.
module ordm_cell import ordm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [BYTE_W-1:0] i_din,
    input  logic [BYTE_W-1:0] i_want,
    input  logic              i_check_en,
    output logic [BYTE_W-1:0] o_q,
    output logic              o_hit
);

    logic [BYTE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_ctl.clear) begin
            r_q <= '0;
        end else if (i_ctl.shift) begin
            r_q <= i_din;
        end
    end

    assign o_q   = r_q;
    assign o_hit = !i_check_en || (i_din == i_want);

endmodule

FILE: hw/rtl/ordered_delimiter_matcher_unit.sv
// Ordered delimiter matcher top level: config registers, control, cell row.
// Each result word is registered in the output register as its byte is accepted.
// Throughput: one byte per cycle while o_stall is low; the compare across the cell row is combinational.
// Reset (synchronous, active low) clears config, window, counters and the output valid flag.
// Depends on ordm_pkg and ordm_cell.
module ordered_delimiter_matcher_unit import ordm_pkg::*; #(
    parameter int MAX_DELIMITERS    = 6,
    parameter int MAX_DELIMITER_LEN = 8,
    parameter int POSITION_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [BYTE_W-1:0]  i_text_byte,
    input  logic               i_end_of_text,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CUR_W-1:0]   o_matched_so_far,
    output logic               o_delimiter_done,
    output logic [START_W-1:0] o_match_start,
    output logic               o_pattern_matched,
    output logic               o_text_done
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [CUR_W-1:0]     r_cfg_count;
    logic [LENGTHS_W-1:0] r_cfg_lengths;
    logic [DELIM_W-1:0]   r_cfg_bytes [NUM_DELIMS];

    logic [LEN_W-1:0]         r_bsm;
    logic [CUR_W-1:0]         r_cur;
    logic [POSITION_BITS-1:0] r_pos;

    logic               r_out_valid;
    logic [CUR_W-1:0]   r_matched;
    logic               r_done;
    logic [START_W-1:0] r_start;
    logic               r_pattern;
    logic               r_text_done;

    logic                     cfg_wr;
    t_reg_idx                 cfg_idx;
    logic                     in_acc;
    logic [CUR_W-1:0]         count_eff;
    logic                     first;
    logic [CUR_W-1:0]         cur1;
    logic                     done1;
    logic [LEN_W-1:0]         bsm1;
    logic [LEN_W-1:0]         len1;
    logic [LEN_W-1:0]         len1_m1;
    logic [DELIM_W-1:0]       sel_bytes;
    logic                     all_hit;
    logic                     match;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] last2;
    logic [CUR_W-1:0]         cur2;
    logic [CUR_W-1:0]         cur3;
    logic [CUR_W-1:0]         n_cur;
    logic [LEN_W-1:0]         n_bsm;
    logic                     n_done;
    logic [POSITION_BITS-1:0] n_last;
    logic                     n_pattern;
    t_cell_ctl                cell_ctl;

    logic [BYTE_W-1:0]           cell_din  [MAX_DELIMITER_LEN];
    logic [BYTE_W-1:0]           cell_q    [MAX_DELIMITER_LEN];
    logic [BYTE_W-1:0]           cell_want [MAX_DELIMITER_LEN];
    logic [MAX_DELIMITER_LEN-1:0] cell_en;
    logic [MAX_DELIMITER_LEN-1:0] cell_hit;

    function automatic logic [LEN_W-1:0] len_of(input logic [CUR_W-1:0] k,
                                                input logic [LENGTHS_W-1:0] lens);
        logic [LEN_W-1:0] l;
        l = '0;
        if (k < CUR_W'(NUM_DELIMS)) begin
            l = lens[LEN_W*k +: LEN_W];
        end
        if (l > LEN_W'(MAX_DELIMITER_LEN)) begin
            l = LEN_W'(MAX_DELIMITER_LEN);
        end
        return l;
    endfunction

    function automatic logic [CUR_W-1:0] skip_empty(input logic [CUR_W-1:0] from,
                                                    input logic [CUR_W-1:0] cnt,
                                                    input logic [LENGTHS_W-1:0] lens);
        logic [CUR_W-1:0] res;
        res = from;
        for (int k = 0; k < NUM_DELIMS; k++) begin
            if (res == CUR_W'(k) && res < cnt && len_of(res, lens) == '0) begin
                res = CUR_W'(k + 1);
            end
        end
        return res;
    endfunction

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count   <= '0;
            r_cfg_lengths <= '0;
            for (int k = 0; k < NUM_DELIMS; k++) begin
                r_cfg_bytes[k] <= '0;
            end
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_COUNT:   r_cfg_count    <= pwdata[CUR_W-1:0];
                REG_LENGTHS: r_cfg_lengths  <= pwdata[LENGTHS_W-1:0];
                REG_BYTES_0: r_cfg_bytes[0] <= pwdata;
                REG_BYTES_1: r_cfg_bytes[1] <= pwdata;
                REG_BYTES_2: r_cfg_bytes[2] <= pwdata;
                REG_BYTES_3: r_cfg_bytes[3] <= pwdata;
                REG_BYTES_4: r_cfg_bytes[4] <= pwdata;
                REG_BYTES_5: r_cfg_bytes[5] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_COUNT:   prdata = DATA_W'(r_cfg_count);
            REG_LENGTHS: prdata = DATA_W'(r_cfg_lengths);
            REG_BYTES_0: prdata = r_cfg_bytes[0];
            REG_BYTES_1: prdata = r_cfg_bytes[1];
            REG_BYTES_2: prdata = r_cfg_bytes[2];
            REG_BYTES_3: prdata = r_cfg_bytes[3];
            REG_BYTES_4: prdata = r_cfg_bytes[4];
            REG_BYTES_5: prdata = r_cfg_bytes[5];
            default:     prdata = '0;
        endcase
    end

    // handshake
    assign o_stall = r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;

    // delimiter selection
    assign count_eff = (r_cfg_count > CUR_W'(MAX_DELIMITERS)) ? CUR_W'(MAX_DELIMITERS)
                                                              : r_cfg_count;
    assign first     = (r_pos == '0) && (r_bsm == '0);
    assign cur1      = first ? skip_empty(r_cur, count_eff, r_cfg_lengths) : r_cur;
    assign done1     = first && (cur1 != r_cur);
    assign bsm1      = (r_bsm == BSM_MAX) ? r_bsm : r_bsm + 1'b1;
    assign len1      = len_of(cur1, r_cfg_lengths);
    assign len1_m1   = len1 - 1'b1;
    assign sel_bytes = (cur1 < CUR_W'(NUM_DELIMS)) ? r_cfg_bytes[cur1] : '0;

    // cell row
    assign cell_ctl.shift = in_acc;
    assign cell_ctl.clear = in_acc && i_end_of_text;

    genvar j;
    generate
        for (j = 0; j < MAX_DELIMITER_LEN; j++) begin : g_cell
            logic [2:0] want_idx;
            if (j == 0) begin : g_head
                assign cell_din[j] = i_text_byte;
            end else begin : g_link
                assign cell_din[j] = cell_q[j-1];
            end
            assign cell_en[j]   = LEN_W'(j) < len1;
            assign want_idx     = 3'(len1_m1 - LEN_W'(j));
            assign cell_want[j] = sel_bytes[BYTE_W*want_idx +: BYTE_W];

            ordm_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (cell_ctl),
                .i_din      (cell_din[j]),
                .i_want     (cell_want[j]),
                .i_check_en (cell_en[j]),
                .o_q        (cell_q[j]),
                .o_hit      (cell_hit[j])
            );
        end
    endgenerate

    assign all_hit = &cell_hit;
    assign match   = (cur1 < count_eff) && (len1 != '0) && (bsm1 >= len1) && all_hit;

    // match bookkeeping
    always_comb begin
        pos_next = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
        last2    = (r_pos >= POSITION_BITS'(len1_m1)) ? r_pos - POSITION_BITS'(len1_m1)
                                                      : '0;
        cur2     = cur1 + 1'b1;
        cur3     = skip_empty(cur2, count_eff, r_cfg_lengths);
        if (match) begin
            n_cur  = cur3;
            n_bsm  = '0;
            n_last = (cur3 != cur2) ? pos_next : last2;
        end else begin
            n_cur  = cur1;
            n_bsm  = bsm1;
            n_last = r_pos;
        end
        n_done    = done1 || match;
        n_pattern = i_end_of_text && (n_cur >= count_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsm <= '0;
            r_cur <= '0;
            r_pos <= '0;
        end else if (in_acc) begin
            if (i_end_of_text) begin
                r_bsm <= '0;
                r_cur <= '0;
                r_pos <= '0;
            end else begin
                r_bsm <= n_bsm;
                r_cur <= n_cur;
                r_pos <= pos_next;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_matched   <= n_cur;
            r_done      <= n_done;
            r_start     <= n_done ? START_W'(n_last) : '0;
            r_pattern   <= n_pattern;
            r_text_done <= i_end_of_text;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_matched_so_far  = r_matched;
    assign o_delimiter_done  = r_done;
    assign o_match_start     = r_start;
    assign o_pattern_matched = r_pattern;
    assign o_text_done       = r_text_done;

    a_cur_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= CUR_W'(MAX_DELIMITERS))
        else $error("delimiter index past limit");

    a_eot_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_end_of_text |=> r_pos == '0 && r_cur == '0 && r_bsm == '0)
        else $error("state not cleared after final byte");

    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_delimiter_done |-> o_match_start == '0)
        else $error("start offset without a completed delimiter");

    a_pattern_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pattern_matched |-> o_text_done)
        else $error("pattern result before final byte");

endmodule

FILE: dv/tb_top.sv
// Testbench for ordered_delimiter_matcher_unit: drives text words, predicts every result word.
// Register writes go through the APB-style port; depends on ordm_pkg and the unit RTL.
module tb_top;
    import ordm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1300;
    localparam int QUIET_FROM   = 1050;
    localparam int LONG_FILL    = 100;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              eot;
    } t_text_item;

    typedef struct packed {
        logic [CUR_W-1:0]   matched;
        logic               done;
        logic [START_W-1:0] start;
        logic               full;
        logic               text_end;
    } t_match_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [BYTE_W-1:0]  i_text_byte = '0;
    logic               i_end_of_text = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [CUR_W-1:0]   o_matched_so_far;
    logic               o_delimiter_done;
    logic [START_W-1:0] o_match_start;
    logic               o_pattern_matched;
    logic               o_text_done;

    ordered_delimiter_matcher_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_text_byte       (i_text_byte),
        .i_end_of_text     (i_end_of_text),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_matched_so_far  (o_matched_so_far),
        .o_delimiter_done  (o_delimiter_done),
        .o_match_start     (o_match_start),
        .o_pattern_matched (o_pattern_matched),
        .o_text_done       (o_text_done)
    );

    always #2 i_clk = ~i_clk;

    // register shadow
    logic [2:0]           cfg_count = '0;
    logic [LENGTHS_W-1:0] cfg_lengths = '0;
    logic [DELIM_W-1:0]   cfg_bytes [NUM_DELIMS];

    // matcher state
    logic [BYTE_W-1:0]  win [8];
    logic [3:0]         since_match = '0;
    logic [CUR_W-1:0]   delim_idx = '0;
    logic [START_W-1:0] text_pos = '0;

    t_text_item  pending_bytes [$];
    t_match_word expected_words [$];
    t_text_item  next_item;
    t_match_word got_word;
    t_match_word want_word;

    bit idle_on = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_req = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int words_sent = 0;
    int random_items = 0;
    int reg_writes = 0;
    int full_hits = 0;
    int phases = 0;

    initial begin
        win = '{default: '0};
        cfg_bytes = '{default: '0};
    end

    function automatic int eff_count();
        return (cfg_count > 3'd6) ? 6 : int'(cfg_count);
    endfunction

    function automatic int eff_len(input int k);
        int l;
        l = int'(cfg_lengths[4*k +: 4]);
        return (l > 8) ? 8 : l;
    endfunction

    function automatic bit window_hit(input int k, input int len);
        for (int i = 0; i < len; i++) begin
            if (win[len-1-i] !== cfg_bytes[k][8*i +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void advance_matcher(input logic [BYTE_W-1:0] b, input logic eot);
        t_match_word w;
        logic [START_W-1:0] pos;
        logic [START_W-1:0] nxt;
        logic [START_W-1:0] start;
        int cnt;
        int len;
        logic hit;
        cnt = eff_count();
        pos = text_pos;
        start = '0;
        hit = 1'b0;
        if (pos == 0 && since_match == 0) begin
            while (delim_idx < cnt && eff_len(delim_idx) == 0) begin
                delim_idx++;
                start = pos;
                hit = 1'b1;
            end
        end
        for (int i = 7; i > 0; i--) win[i] = win[i-1];
        win[0] = b;
        if (since_match != 4'hF) since_match++;
        if (delim_idx < cnt) begin
            len = eff_len(delim_idx);
            if (len > 0 && since_match >= len && window_hit(delim_idx, len)) begin
                nxt = (pos != '1) ? pos + 1'b1 : pos;
                start = (pos >= len - 1) ? START_W'(pos - (len - 1)) : '0;
                hit = 1'b1;
                delim_idx++;
                since_match = '0;
                while (delim_idx < cnt && eff_len(delim_idx) == 0) begin
                    delim_idx++;
                    start = nxt;
                end
            end
        end
        if (text_pos != '1) text_pos++;
        w.matched  = delim_idx;
        w.done     = hit;
        w.start    = hit ? start : '0;
        w.full     = eot && (delim_idx >= cnt);
        w.text_end = eot;
        if (w.full) full_hits++;
        expected_words = {expected_words, w};
        if (eot) begin
            win = '{default: '0};
            since_match = '0;
            delim_idx = '0;
            text_pos = '0;
        end
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                advance_matcher(i_text_byte, i_end_of_text);
                words_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_bytes.size() > 0 && idle_on &&
                             $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 6) - 1;
                    i_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    next_item = pending_bytes.pop_front();
                    i_valid <= 1'b1;
                    i_text_byte <= next_item.b;
                    i_end_of_text <= next_item.eot;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got_word = '{matched: o_matched_so_far, done: o_delimiter_done,
                             start: o_match_start, full: o_pattern_matched,
                             text_end: o_text_done};
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: %s=%0d done=%0d start=%0d %s=%0d end=%0d",
                                 "matched", got_word.matched, got_word.done,
                                 got_word.start, "full", got_word.full,
                                 got_word.text_end);
                end else begin
                    want_word = expected_words.pop_front();
                    if (got_word.matched !== want_word.matched ||
                        got_word.done !== want_word.done ||
                        got_word.start !== want_word.start ||
                        got_word.full !== want_word.full ||
                        got_word.text_end !== want_word.text_end) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: got matched=%0d done=%0d start=%0d %s=%0d end=%0d",
                                     got_word.matched, got_word.done, got_word.start,
                                     "full", got_word.full, got_word.text_end);
                            $display("  expected matched=%0d done=%0d start=%0d %s=%0d end=%0d",
                                     want_word.matched, want_word.done, want_word.start,
                                     "full", want_word.full, want_word.text_end);
                        end
                    end
                end
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d result words outstanding",
                     cycle_count, expected_words.size());
            $display("ordered_delimiter_matcher_unit verification failed");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 3'b000});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_COUNT:   cfg_count = val[2:0];
            REG_LENGTHS: cfg_lengths = val[LENGTHS_W-1:0];
            default:     cfg_bytes[int'(idx) - int'(REG_BYTES_0)] = val;
        endcase
        reg_writes++;
        @(negedge i_clk);
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eot);
        t_text_item it;
        it.b = b;
        it.eot = eot;
        pending_bytes = {pending_bytes, it};
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || i_valid || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        phases++;
    endtask

    function automatic logic [BYTE_W-1:0] letter();
        return 8'h61 + 8'($urandom_range(0, 2));
    endfunction

    task automatic random_phase(input int target, input bit mid_drain);
        logic [BYTE_W-1:0] txt [$];
        logic [DELIM_W-1:0] pat;
        logic [LENGTHS_W-1:0] lens;
        logic [2:0] cnt;
        int n;
        int mode;
        int skip;
        int f;
        bit eot_last;
        bit drained;
        cnt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                          : 3'($urandom_range(1, 6));
        for (int k = 0; k < NUM_DELIMS; k++)
            lens[4*k +: 4] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                         : 4'($urandom_range(0, 4));
        write_reg(REG_COUNT, {$urandom, $urandom});
        write_reg(REG_COUNT, {$urandom, 29'($urandom), cnt});
        write_reg(REG_LENGTHS, {$urandom, 8'($urandom), lens});
        for (int k = 0; k < NUM_DELIMS; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                pat = {$urandom, $urandom};
            end else begin
                for (int i = 0; i < 8; i++) pat[8*i +: 8] = letter();
            end
            write_reg(t_reg_idx'(int'(REG_BYTES_0) + k), pat);
        end
        n = 0;
        drained = 1'b0;
        while (n < target) begin
            txt.delete();
            mode = $urandom_range(0, 9);
            if (mode == 9) begin
                repeat ($urandom_range(1, 12)) txt = {txt, 8'($urandom)};
            end else begin
                skip = (mode >= 7) ? $urandom_range(0, 6) : 7;
                for (int k = 0; k < eff_count(); k++) begin
                    f = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20)
                                                    : $urandom_range(0, 4);
                    repeat (f) txt = {txt, letter()};
                    if (k != skip)
                        for (int i = 0; i < eff_len(k); i++)
                            txt = {txt, cfg_bytes[k][8*i +: 8]};
                end
                repeat ($urandom_range(0, 3)) txt = {txt, letter()};
                if (txt.size() == 0) txt = {txt, letter()};
            end
            eot_last = !((n + txt.size() >= target) && $urandom_range(0, 2) == 0);
            foreach (txt[i]) push_byte(txt[i], eot_last && i == txt.size() - 1);
            n += txt.size();
            if (mid_drain && !drained && n >= target / 2) begin
                drained = 1'b1;
                wait_drained();
            end
        end
        random_items += n;
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // count above six, zero-length first and after a match, length above eight
        write_reg(REG_COUNT, '1);
        write_reg(REG_LENGTHS, 64'hFFFF_FFFF_FF01_F020);
        write_reg(REG_BYTES_0, '0);
        write_reg(REG_BYTES_1, 64'h6261);
        write_reg(REG_BYTES_2, '0);
        write_reg(REG_BYTES_3, '1);
        write_reg(REG_BYTES_4, '0);
        write_reg(REG_BYTES_5, {$urandom, $urandom});
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        repeat (8) push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_drained();

        // empty pattern matches anything
        write_reg(REG_COUNT, '0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_drained();

        // all lengths at maximum
        write_reg(REG_COUNT, 64'd1);
        write_reg(REG_LENGTHS, 64'hFF_FFFF);
        repeat (7) push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_drained();

        while (random_items < RANDOM_WORDS) begin
            idle_on = (random_items < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            if (phases == 4) begin
                idle_on = 1'b0;
                hold_req = 150;
            end
            random_phase($urandom_range(60, 160), phases == 5);
            if (phases == 8) begin
                // one long text with a late match and a trailing empty delimiter
                idle_on = 1'b0;
                write_reg(REG_COUNT, 64'd2);
                write_reg(REG_LENGTHS, 64'd3);
                write_reg(REG_BYTES_0, 64'h33_2211);
                repeat (LONG_FILL) push_byte(8'h00, 1'b0);
                push_byte(8'h11, 1'b0);
                push_byte(8'h22, 1'b0);
                push_byte(8'h33, 1'b1);
                wait_drained();
            end
        end
        idle_on = 1'b0;
        wait_drained();

        $display("covered %0d text words (%0d random) over %0d phases and %0d register writes",
                 words_sent, random_items, phases, reg_writes);
        $display("%0d full-pattern hits, one long text with a late match, %0d mismatches",
                 full_hits, mismatches);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("ordered_delimiter_matcher_unit verification clean");
        end else begin
            $display("ordered_delimiter_matcher_unit verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ordm_pkg.sv
hw/rtl/ordm_cell.sv
hw/rtl/ordered_delimiter_matcher_unit.sv
dv/tb_top.sv
